// File: hdl/slp_pkg.sv
// Shared types and constants for the scope latency profiler.
// No dependencies.
`timescale 1ns / 1ps
package slp_pkg;
	localparam int SLOTS_DEF = 32;
	localparam int SLOT_W = 5;
	localparam int HIT_W = 24;
	localparam int TOT_W = 48;
	localparam int TS_W = 32;
	localparam int FPR_W = 8;
	localparam logic [FPR_W-1:0] FPR_RESET = 8'd120;

	localparam logic [1:0] REQ_START = 2'd0;
	localparam logic [1:0] REQ_STOP  = 2'd1;
	localparam logic [1:0] REQ_FRAME = 2'd2;

	// controller -> datapath commands
	typedef struct packed {
		logic rd;       // read slot stats
		logic upd;      // write back start/stop update
		logic clr;      // clear stats of slot at rpt index
		logic div_go;   // start both dividers
		logic emit;     // present a report item
	} cmd_t;

	typedef struct packed {
		logic div_done;
	} sts_t;
endpackage

// File: hdl/slp_div.sv
// Restoring radix-2 divider, 48-bit dividend, 48-bit divisor, one bit a cycle.
// Uses slp_pkg. Divide by zero gives zero.
`timescale 1ns / 1ps
module slp_div (
	input  logic clk,
	input  logic arst_n,
	input  logic go,
	input  logic [slp_pkg::TOT_W-1:0] num,
	input  logic [slp_pkg::TOT_W-1:0] den,
	output logic done,
	output logic [slp_pkg::TOT_W-1:0] quo
);
	localparam int W = slp_pkg::TOT_W;
	logic [W-1:0] q_q, d_q;
	logic [W:0] r_q;
	logic [5:0] cnt_q;
	logic run_q, zero_q;
	logic [W:0] r_sh;
	logic [W:0] diff;

	assign r_sh = {r_q[W-1:0], q_q[W-1]};
	assign diff = r_sh - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= 6'(W);
			end else if (run_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					run_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			q_q <= num;
			d_q <= den;
			r_q <= '0;
			zero_q <= (den == '0);
		end else if (run_q) begin
			if (!diff[W]) begin
				r_q <= diff;
				q_q <= {q_q[W-2:0], 1'b1};
			end else begin
				r_q <= r_sh;
				q_q <= {q_q[W-2:0], 1'b0};
			end
		end
	end

	assign quo = zero_q ? '0 : q_q;
endmodule

// File: hdl/slp_datapath.sv
// Slot statistics memories, update arithmetic, report dividers and outputs.
// Uses slp_pkg and slp_div.
`timescale 1ns / 1ps
module slp_datapath #(
	parameter int SLOTS = slp_pkg::SLOTS_DEF,
	parameter int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
	input  logic clk,
	input  logic arst_n,
	input  slp_pkg::cmd_t cmd,
	output slp_pkg::sts_t sts,
	input  logic [1:0] req_type,
	input  logic [slp_pkg::SLOT_W-1:0] slot,
	input  logic [slp_pkg::TS_W-1:0] timestamp,
	input  logic [IW-1:0] rpt_idx,
	input  logic rpt_last,
	input  logic [slp_pkg::FPR_W-1:0] frames_per_report,
	output logic [slp_pkg::SLOT_W-1:0] report_slot,
	output logic [slp_pkg::HIT_W-1:0] hit_count,
	output logic [slp_pkg::TOT_W-1:0] mean_per_call,
	output logic [slp_pkg::TOT_W-1:0] mean_per_frame,
	output logic [slp_pkg::TOT_W-1:0] total_time,
	output logic [slp_pkg::TS_W-1:0] min_time,
	output logic [slp_pkg::TS_W-1:0] max_time,
	output logic last
);
	localparam int TW = slp_pkg::TOT_W;
	localparam int SW = slp_pkg::TS_W;
	localparam int HW = slp_pkg::HIT_W;

	// Stats stores; reset values come from per-slot valid bits.
	logic [SW-1:0] stamp_m [SLOTS];
	logic [HW-1:0] hits_m [SLOTS];
	logic [TW-1:0] tot_m [SLOTS];
	logic [SW-1:0] min_m [SLOTS];
	logic [SW-1:0] max_m [SLOTS];
	logic [SLOTS-1:0] sv_q;  // stamp written since reset
	logic [SLOTS-1:0] xv_q;  // stats valid since last clear

	logic [IW-1:0] a;
	logic [1:0] kind_q;
	logic [IW-1:0] a_q;
	logic [SW-1:0] ts_q, stamp_q, min_q, max_q;
	logic [HW-1:0] hits_q;
	logic [TW-1:0] tot_q;
	logic [SW-1:0] d;
	logic [TW:0] tsum;

	assign a = cmd.clr || cmd.div_go || cmd.emit ? rpt_idx : IW'(slot);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sv_q <= '0;
			xv_q <= '0;
		end else begin
			if (cmd.upd) begin
				sv_q[a_q] <= 1'b1;
				xv_q[a_q] <= 1'b1;
			end
			if (cmd.clr)
				xv_q[rpt_idx] <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd || cmd.div_go) begin
			a_q <= a;
			kind_q <= req_type;
			ts_q <= timestamp;
			stamp_q <= sv_q[a] ? stamp_m[a] : '0;
			hits_q <= xv_q[a] ? hits_m[a] : '0;
			tot_q <= xv_q[a] ? tot_m[a] : '0;
			min_q <= xv_q[a] ? min_m[a] : '1;
			max_q <= xv_q[a] ? max_m[a] : '0;
		end
		if (cmd.upd) begin
			if (kind_q == slp_pkg::REQ_START) begin
				stamp_m[a_q] <= ts_q;
				hits_m[a_q] <= (hits_q == '1) ? hits_q : hits_q + HW'(1);
				tot_m[a_q] <= tot_q;
				min_m[a_q] <= min_q;
				max_m[a_q] <= max_q;
			end else begin
				stamp_m[a_q] <= '0;
				hits_m[a_q] <= hits_q;
				tot_m[a_q] <= tsum[TW] ? '1 : tsum[TW-1:0];
				min_m[a_q] <= (d < min_q) ? d : min_q;
				max_m[a_q] <= (d > max_q) ? d : max_q;
			end
		end
	end

	assign d = ts_q - stamp_q;
	assign tsum = {1'b0, tot_q} + {{(TW+1-SW){1'b0}}, d};

	logic dn1, dn2;
	logic [TW-1:0] q1, q2;
	logic [TW-1:0] fdiv;
	assign fdiv = (frames_per_report == '0) ? TW'(256) : TW'(frames_per_report);

	slp_div u_div_call (
		.clk(clk), .arst_n(arst_n), .go(cmd.div_go),
		.num(xv_q[a] ? tot_m[a] : '0), .den(xv_q[a] ? TW'(hits_m[a]) : '0),
		.done(dn1), .quo(q1)
	);
	slp_div u_div_frame (
		.clk(clk), .arst_n(arst_n), .go(cmd.div_go),
		.num(xv_q[a] ? tot_m[a] : '0), .den(fdiv),
		.done(dn2), .quo(q2)
	);
	assign sts.div_done = dn1 & dn2;

	logic no_stop;
	assign no_stop = (min_q == '1) && (max_q != '1);
	assign report_slot = slp_pkg::SLOT_W'(a_q);
	assign hit_count = hits_q;
	assign mean_per_call = q1;
	assign mean_per_frame = q2;
	assign total_time = tot_q;
	assign min_time = no_stop ? '0 : min_q;
	assign max_time = max_q;
	assign last = rpt_last;
endmodule

// File: hdl/slp_ctrl.sv
// Controller: sequences slot updates, frame counting and the report walk.
// Uses slp_pkg.
`timescale 1ns / 1ps
module slp_ctrl #(
	parameter int SLOTS = slp_pkg::SLOTS_DEF,
	parameter int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [1:0] req_type,
	input  logic [slp_pkg::SLOT_W-1:0] slot,
	input  logic [slp_pkg::FPR_W-1:0] frames_per_report,
	input  slp_pkg::sts_t sts,
	output slp_pkg::cmd_t cmd,
	output logic [IW-1:0] rpt_idx,
	output logic rpt_last,
	output logic busy,
	output logic strobe
);
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_UPD  = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;
	localparam logic [1:0] ST_EMIT = 2'd3;

	logic [1:0] state_q;
	logic [slp_pkg::FPR_W-1:0] frame_q, fnext;
	logic [IW-1:0] idx_q;
	logic go_q;
	logic acc, hit;

	assign acc = start && !busy;
	assign fnext = frame_q + 8'd1;
	assign hit = (req_type == slp_pkg::REQ_START || req_type == slp_pkg::REQ_STOP)
		&& (32'(slot) < SLOTS);
	assign busy = (state_q != ST_IDLE);
	assign rpt_idx = idx_q;
	assign rpt_last = (32'(idx_q) == SLOTS - 1);
	assign strobe = (state_q == ST_EMIT);

	always_comb begin
		cmd = '0;
		cmd.rd = acc && hit;
		cmd.upd = (state_q == ST_UPD);
		cmd.div_go = go_q;
		cmd.emit = (state_q == ST_EMIT);
		cmd.clr = (state_q == ST_EMIT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			frame_q <= '0;
			idx_q <= '0;
			go_q <= 1'b0;
		end else begin
			go_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (acc && hit)
						state_q <= ST_UPD;
					else if (acc && req_type == slp_pkg::REQ_FRAME) begin
						if (fnext == frames_per_report) begin
							frame_q <= '0;
							idx_q <= '0;
							go_q <= 1'b1;
							state_q <= ST_DIV;
						end else
							frame_q <= fnext;
					end
				end
				ST_UPD: state_q <= ST_IDLE;
				ST_DIV: begin
					if (sts.div_done)
						state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (rpt_last)
						state_q <= ST_IDLE;
					else begin
						idx_q <= idx_q + IW'(1);
						go_q <= 1'b1;
						state_q <= ST_DIV;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// File: hdl/scope_latency_profiler.sv
// Top level of the scope latency profiler: config register, controller, datapath.
// Uses slp_pkg, slp_ctrl, slp_datapath.
`timescale 1ns / 1ps
// Start/stop items are a read then a write back of one slot. A closing frame
// walks every slot: per slot the two 48-step bit-serial dividers run, then one
// cycle with the report on the outputs and strobe high. Reports cannot be held
// off; busy stays high until the last one.
module scope_latency_profiler #(
	parameter int SLOTS = slp_pkg::SLOTS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  logic [1:0] req_type,
	input  logic [slp_pkg::SLOT_W-1:0] slot,
	input  logic [slp_pkg::TS_W-1:0] timestamp,
	input  logic cfg_we,
	input  logic [slp_pkg::FPR_W-1:0] cfg_wdata,
	output logic strobe,
	output logic [slp_pkg::SLOT_W-1:0] report_slot,
	output logic [slp_pkg::HIT_W-1:0] hit_count,
	output logic [slp_pkg::TOT_W-1:0] mean_per_call,
	output logic [slp_pkg::TOT_W-1:0] mean_per_frame,
	output logic [slp_pkg::TOT_W-1:0] total_time,
	output logic [slp_pkg::TS_W-1:0] min_time,
	output logic [slp_pkg::TS_W-1:0] max_time,
	output logic last
);
	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	logic [slp_pkg::FPR_W-1:0] fpr_q;
	slp_pkg::cmd_t cmd;
	slp_pkg::sts_t sts;
	logic [IW-1:0] rpt_idx;
	logic rpt_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			fpr_q <= slp_pkg::FPR_RESET;
		else if (cfg_we)
			fpr_q <= cfg_wdata;
	end

	slp_ctrl #(.SLOTS(SLOTS), .IW(IW)) u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .req_type(req_type), .slot(slot),
		.frames_per_report(fpr_q), .sts(sts), .cmd(cmd), .rpt_idx(rpt_idx),
		.rpt_last(rpt_last), .busy(busy), .strobe(strobe)
	);

	slp_datapath #(.SLOTS(SLOTS), .IW(IW)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts), .req_type(req_type),
		.slot(slot), .timestamp(timestamp), .rpt_idx(rpt_idx), .rpt_last(rpt_last),
		.frames_per_report(fpr_q), .report_slot(report_slot), .hit_count(hit_count),
		.mean_per_call(mean_per_call), .mean_per_frame(mean_per_frame),
		.total_time(total_time), .min_time(min_time), .max_time(max_time), .last(last)
	);

	a_strobe_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> busy) else $error("report without busy");
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last |=> !strobe) else $error("report after last");
	a_upd_after_rd: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd |=> cmd.upd) else $error("read without write back");
endmodule
